// ===== hw/rtl/hlpc_pkg.sv =====
// Shared types and constants for the hex line packet collector.
package hlpc_pkg;

  localparam int PACKET_BYTES = 128;
  localparam int LOW_BYTES    = 80;   // bytes kept in the RAM
  localparam int HI_BYTES     = PACKET_BYTES - LOW_BYTES;  // bytes kept in flops
  localparam int HI_IDX_W     = $clog2(HI_BYTES);
  localparam int IDX_W        = $clog2(PACKET_BYTES);
  localparam int COUNT_W      = IDX_W + 2;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(2 * PACKET_BYTES);

  localparam logic [7:0] CHAR_ETX   = 8'h03;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_CARET = 8'h5E;
  localparam logic [7:0] CHAR_UP_C  = 8'h43;

  localparam logic [31:0] ECHO_CANCEL = {CHAR_LF, CHAR_CR, CHAR_UP_C, CHAR_CARET};
  localparam logic [31:0] ECHO_EOL    = {16'h0000, CHAR_LF, CHAR_CR};

  typedef enum logic [1:0] {
    CMD_FEED   = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } hlpc_cmd_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_READY    = 2'd1,
    EV_REJECTED = 2'd2,
    EV_CANCEL   = 2'd3
  } hlpc_event_e;

  typedef struct packed {
    logic        clear;
    logic        set_rejected;
    logic        set_done;
    logic        after_cr_load;
    logic        after_cr_value;
    logic        write_digit;
    logic [3:0]  nibble;
    hlpc_event_e line_event;
    logic [2:0]  echo_count;
    logic [31:0] echo_chars;
  } hlpc_action_t;

endpackage

// ===== hw/rtl/hlpc_decode.sv =====
// Per-item decision logic: what one command and byte do to the line state.
module hlpc_decode
  import hlpc_pkg::*;
(
  input  logic [1:0]         command,
  input  logic [7:0]         data_byte,
  input  logic               begin_after_cr,
  input  logic               after_cr,
  input  logic               line_done,
  input  logic               line_rejected,
  input  logic [COUNT_W-1:0] digit_count,
  output hlpc_action_t       action
);

  logic       is_num;
  logic       is_hex_alpha;
  logic [7:0] num_off;
  logic [7:0] alpha_off;

  assign is_num       = data_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_hex_alpha = data_byte inside {[CHAR_LOW_A:CHAR_LOW_F]};
  assign num_off      = data_byte - CHAR_ZERO;
  assign alpha_off    = data_byte - CHAR_LOW_A + 8'd10;

  always_comb begin
    action                = '0;
    action.line_event     = EV_NONE;
    action.nibble         = is_num ? num_off[3:0] : alpha_off[3:0];
    case (hlpc_cmd_e'(command))
      CMD_BEGIN: begin
        action.clear          = 1'b1;
        action.after_cr_load  = 1'b1;
        action.after_cr_value = begin_after_cr;
      end
      CMD_FEED: begin
        if (!line_done) begin
          action.after_cr_load = 1'b1;
          if (data_byte == CHAR_LF && after_cr) begin
            // LF of a CR LF pair is swallowed
            action.after_cr_value = 1'b0;
          end else if (data_byte == CHAR_ETX) begin
            action.clear        = 1'b1;
            action.set_rejected = 1'b1;
            action.set_done     = 1'b1;
            action.line_event   = EV_CANCEL;
            action.echo_count   = 3'd4;
            action.echo_chars   = ECHO_CANCEL;
          end else if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
            action.after_cr_value = (data_byte == CHAR_CR);
            action.set_done       = 1'b1;
            action.echo_count     = 3'd2;
            action.echo_chars     = ECHO_EOL;
            if (!line_rejected && digit_count == FULL_COUNT) begin
              action.line_event = EV_READY;
            end else begin
              action.clear        = 1'b1;
              action.set_rejected = 1'b1;
              action.line_event   = EV_REJECTED;
            end
          end else if (!line_rejected) begin
            if ((is_num || is_hex_alpha) && digit_count < FULL_COUNT) begin
              action.write_digit = 1'b1;
              action.echo_count  = 3'd1;
              action.echo_chars  = {24'h000000, data_byte};
            end else begin
              action.clear        = 1'b1;
              action.set_rejected = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/hex_line_packet_collector.sv =====
// Top level of the hex line packet collector: line state, packet store, result register.
//
// Takes one item per cycle and returns exactly one result per item, registered in the
// cycle after acceptance; a held result does not block the next item as long as out_ready
// is high at that edge. Each item is decoded in one pass and lands in the result register
// together with the updated state. Packet bytes 80 to 127 live in flops so that the six
// command words come out with every result; bytes 0 to 79 sit in a one-write,
// one-read RAM whose read data is registered with the result. A begin, cancel or reject
// clears the store at once: RAM bytes beyond the digit count read as zero, so no
// clearing pass is needed after reset or between lines.
module hex_line_packet_collector
  import hlpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic        begin_after_cr,
  input  logic [6:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  line_event,
  output logic [2:0]  echo_count,
  output logic [31:0] echo_chars,
  output logic [7:0]  read_data,
  output logic [63:0] word_at_80,
  output logic [63:0] word_at_120,
  output logic [63:0] word_at_88,
  output logic [63:0] word_at_96,
  output logic [63:0] word_at_104,
  output logic [63:0] word_at_112
);

  logic               accept;
  hlpc_action_t       action;

  logic               after_cr;
  logic               line_done;
  logic               line_rejected;
  logic [COUNT_W-1:0] digit_count;
  logic [3:0]         held_nibble;

  logic [7:0]         low_ram [LOW_BYTES];
  logic [7:0]         hi_bytes [HI_BYTES];
  logic [7:0]         hi_bytes_next [HI_BYTES];

  logic [IDX_W-1:0]   wr_idx;
  logic               wr_low;
  logic [HI_IDX_W-1:0] wr_hi_idx;
  logic [7:0]         wr_byte;

  logic               rd_low;
  logic               rd_present;
  logic [IDX_W-1:0]   rd_addr;
  logic [HI_IDX_W-1:0] rd_hi_idx;
  logic [IDX_W-1:0]   rd_hi_off;
  logic [IDX_W-1:0]   wr_hi_off;

  logic               rd_from_ram;
  logic [7:0]         ram_data;
  logic [7:0]         hi_data;

  function automatic logic [63:0] word_from(input logic [7:0] b [HI_BYTES],
                                            input int base);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[8*k +: 8] = b[base - LOW_BYTES + k];
    end
    return w;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  hlpc_decode u_decode (
    .command        (command),
    .data_byte      (data_byte),
    .begin_after_cr (begin_after_cr),
    .after_cr       (after_cr),
    .line_done      (line_done),
    .line_rejected  (line_rejected),
    .digit_count    (digit_count),
    .action         (action)
  );

  // digits are written strictly in order, so the count doubles as the fill mark
  assign wr_idx    = digit_count[IDX_W:1];
  assign wr_low    = wr_idx < IDX_W'(LOW_BYTES);
  assign wr_hi_off = wr_idx - IDX_W'(LOW_BYTES);
  assign wr_hi_idx = wr_hi_off[HI_IDX_W-1:0];
  assign wr_byte   = digit_count[0] ? {held_nibble, action.nibble} : {action.nibble, 4'h0};

  assign rd_low     = read_index < IDX_W'(LOW_BYTES);
  assign rd_present = {1'b0, read_index, 1'b0} < digit_count;
  assign rd_addr    = rd_low ? read_index : '0;
  assign rd_hi_off  = read_index - IDX_W'(LOW_BYTES);
  assign rd_hi_idx  = rd_hi_off[HI_IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < HI_BYTES; i++) begin
      if (action.clear) begin
        hi_bytes_next[i] = 8'h00;
      end else if (action.write_digit && !wr_low && wr_hi_idx == HI_IDX_W'(i)) begin
        hi_bytes_next[i] = wr_byte;
      end else begin
        hi_bytes_next[i] = hi_bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action.write_digit && wr_low) begin
      low_ram[wr_idx] <= wr_byte;
    end
    if (accept) begin
      ram_data <= low_ram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_cr      <= 1'b0;
      line_done     <= 1'b0;
      line_rejected <= 1'b0;
      digit_count   <= '0;
      for (int i = 0; i < HI_BYTES; i++) begin
        hi_bytes[i] <= 8'h00;
      end
    end else if (accept) begin
      hi_bytes <= hi_bytes_next;
      if (action.clear) begin
        line_done     <= 1'b0;
        line_rejected <= 1'b0;
        digit_count   <= '0;
      end
      if (action.set_rejected) begin
        line_rejected <= 1'b1;
      end
      if (action.set_done) begin
        line_done <= 1'b1;
      end
      if (action.after_cr_load) begin
        after_cr <= action.after_cr_value;
      end
      if (action.write_digit) begin
        digit_count <= digit_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action.write_digit) begin
      held_nibble <= action.nibble;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_event  <= action.line_event;
      echo_count  <= action.echo_count;
      echo_chars  <= action.echo_chars;
      rd_from_ram <= (command == CMD_READ) && rd_low && rd_present;
      hi_data     <= (command == CMD_READ && !rd_low) ? hi_bytes[rd_hi_idx] : 8'h00;
      word_at_80  <= word_from(hi_bytes_next, 80);
      word_at_120 <= word_from(hi_bytes_next, 120);
      word_at_88  <= word_from(hi_bytes_next, 88);
      word_at_96  <= word_from(hi_bytes_next, 96);
      word_at_104 <= word_from(hi_bytes_next, 104);
      word_at_112 <= word_from(hi_bytes_next, 112);
    end
  end

  assign read_data = rd_from_ram ? ram_data : hi_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= FULL_COUNT)
    else $error("digit count beyond full packet");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_FEED && line_done
    |=> line_done && $stable(digit_count) && $stable(line_rejected))
    else $error("feed after line end changed line state");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_event == EV_READY |-> line_done && digit_count == FULL_COUNT)
    else $error("ready reported without a full line");

  a_reject_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (line_event == EV_REJECTED || line_event == EV_CANCEL)
    |-> line_rejected && line_done && digit_count == '0)
    else $error("rejected line left state behind");

  a_echo_digit: assert property (@(posedge clk) disable iff (rst)
    accept && action.write_digit |=> digit_count == $past(digit_count) + COUNT_W'(1))
    else $error("stored digit not counted");

endmodule
